/* design/crcpr_pkg.sv */
package crcpr_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 256;
   localparam int COUNT_W              = 8;
   localparam int HEADER_LEN           = 4;

   localparam logic [7:0]  SYNC_BYTE_RESET = 8'hA5;
   localparam logic [7:0]  CRC8_POLY       = 8'h07;
   localparam logic [15:0] CRC16_POLY      = 16'h8408;
   localparam logic [15:0] CRC16_INIT      = 16'hFFFF;

   typedef enum logic {
      OP_RX_BYTE = 1'b0,
      OP_READ    = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      RESP_ACK          = 2'd0,
      RESP_BAD_HEADER   = 2'd1,
      RESP_BAD_DATA     = 2'd2,
      RESP_OVERRUN      = 2'd3
   } resp_code_type;

   typedef enum logic [1:0] {
      PHASE_WAIT   = 2'd0,
      PHASE_HEADER = 2'd1,
      PHASE_BODY   = 2'd2
   } phase_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  data_byte;
   } req_payload_type;

   typedef struct packed {
      logic          resp_valid;
      resp_code_type resp_code;
      logic [7:0]    resp_cookie;
      logic          read_valid;
      logic [7:0]    read_data;
      logic [7:0]    available_count;
   } rsp_payload_type;

   // Everything of a result except the byte that comes out of the ring memory
   typedef struct packed {
      logic          resp_valid;
      resp_code_type resp_code;
      logic [7:0]    resp_cookie;
      logic          read_valid;
      logic [7:0]    available_count;
   } step_result_type;

   // CRC-8, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc ^ d;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // Reflected CRC-CCITT, LSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {8'h00, d};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ({1'b0, c[15:1]} ^ CRC16_POLY) : {1'b0, c[15:1]};
      end
      return c;
   endfunction

endpackage

/* design/crcpr_ring_mem.sv */
module crcpr_ring_mem #(
   parameter int BUFFER_DEPTH = crcpr_pkg::BUFFER_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(BUFFER_DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [7:0]       wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [7:0]       rd_data
);

   logic [7:0] ring_mem [BUFFER_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/crcpr_frame_ctrl.sv */
module crcpr_frame_ctrl #(
   parameter int BUFFER_DEPTH = crcpr_pkg::BUFFER_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(BUFFER_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [7:0]                  csr_write_data,
   input  logic                        item_accept,
   input  crcpr_pkg::req_payload_type  item,
   output crcpr_pkg::step_result_type  result,
   output logic                        mem_wr_en,
   output logic [IDX_W-1:0]            mem_wr_addr,
   output logic [7:0]                  mem_wr_data,
   output logic                        mem_rd_en,
   output logic [IDX_W-1:0]            mem_rd_addr
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
   localparam logic [crcpr_pkg::COUNT_W-1:0] PROV_LIMIT =
      crcpr_pkg::COUNT_W'(BUFFER_DEPTH - 1);
   localparam logic [2:0] HDR_DONE = 3'(crcpr_pkg::HEADER_LEN);

   crcpr_pkg::phase_type phase_ff, phase_in;

   logic [7:0]  sync_byte_ff;
   logic [2:0]  header_index_ff, header_index_in;
   logic [7:0]  cookie_ff, cookie_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic [15:0] expected_crc_ff, expected_crc_in;
   logic [7:0]  header_crc_ff, header_crc_in;
   logic [15:0] body_crc_ff, body_crc_in;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] commit_index_ff, commit_index_in;
   logic [IDX_W-1:0] prov_index_ff, prov_index_in;
   logic [crcpr_pkg::COUNT_W-1:0] committed_count_ff, committed_count_in;
   logic [crcpr_pkg::COUNT_W-1:0] prov_count_ff, prov_count_in;

   logic        is_rx;
   logic        hdr_complete;
   logic        hdr_match;
   logic        body_room;
   logic        body_last;
   logic        body_good;
   logic [15:0] body_crc_next;
   logic [7:0]  remaining_dec;
   logic [IDX_W-1:0] read_next;
   logic [IDX_W-1:0] prov_next;

   assign is_rx         = item_accept && (item.opcode == crcpr_pkg::OP_RX_BYTE);
   assign hdr_complete  = (header_index_ff >= HDR_DONE);
   assign hdr_match     = (item.data_byte == header_crc_ff);
   assign body_room     = (prov_count_ff < PROV_LIMIT);
   assign remaining_dec = remaining_ff - 8'd1;
   assign body_last     = (remaining_dec == 8'd0);
   assign body_crc_next = crcpr_pkg::crc16_step(body_crc_ff, item.data_byte);
   assign body_good     = (expected_crc_ff == 16'h0000) || (body_crc_next == expected_crc_ff);
   assign read_next     = (read_index_ff == LAST_IDX) ? '0 : read_index_ff + 1'b1;
   assign prov_next     = (prov_index_ff == LAST_IDX) ? '0 : prov_index_ff + 1'b1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_rx) begin
         case (phase_ff)
            crcpr_pkg::PHASE_HEADER: begin
               if (hdr_complete) begin
                  phase_in = (hdr_match && remaining_ff != 8'd0) ?
                             crcpr_pkg::PHASE_BODY : crcpr_pkg::PHASE_WAIT;
               end
            end
            crcpr_pkg::PHASE_BODY: begin
               if (!body_room || body_last) begin
                  phase_in = crcpr_pkg::PHASE_WAIT;
               end
            end
            default: begin
               phase_in = (item.data_byte == sync_byte_ff) ?
                          crcpr_pkg::PHASE_HEADER : crcpr_pkg::PHASE_WAIT;
            end
         endcase
      end
   end

   // datapath, ring commands and result
   always_comb begin
      header_index_in    = header_index_ff;
      cookie_in          = cookie_ff;
      remaining_in       = remaining_ff;
      expected_crc_in    = expected_crc_ff;
      header_crc_in      = header_crc_ff;
      body_crc_in        = body_crc_ff;
      read_index_in      = read_index_ff;
      commit_index_in    = commit_index_ff;
      prov_index_in      = prov_index_ff;
      committed_count_in = committed_count_ff;
      prov_count_in      = prov_count_ff;
      mem_wr_en          = 1'b0;
      mem_rd_en          = 1'b0;
      result             = '0;

      if (item_accept && item.opcode == crcpr_pkg::OP_READ) begin
         if (committed_count_ff != '0) begin
            mem_rd_en          = 1'b1;
            result.read_valid  = 1'b1;
            read_index_in      = read_next;
            committed_count_in = committed_count_ff - 1'b1;
            prov_count_in      = prov_count_ff - 1'b1;
         end
      end else if (is_rx) begin
         case (phase_ff)
            crcpr_pkg::PHASE_HEADER: begin
               if (hdr_complete) begin
                  if (hdr_match) begin
                     if (remaining_ff != 8'd0) begin
                        body_crc_in   = crcpr_pkg::CRC16_INIT;
                        prov_index_in = commit_index_ff;
                        prov_count_in = committed_count_ff;
                     end else if (cookie_ff != 8'd0) begin
                        result.resp_valid  = 1'b1;
                        result.resp_code   = crcpr_pkg::RESP_ACK;
                        result.resp_cookie = cookie_ff;
                     end
                  end else begin
                     result.resp_valid = 1'b1;
                     result.resp_code  = crcpr_pkg::RESP_BAD_HEADER;
                  end
               end else begin
                  case (header_index_ff[1:0])
                     2'd0:    cookie_in             = item.data_byte;
                     2'd1:    remaining_in          = item.data_byte;
                     2'd2:    expected_crc_in[7:0]  = item.data_byte;
                     default: expected_crc_in[15:8] = item.data_byte;
                  endcase
                  header_index_in = header_index_ff + 3'd1;
                  header_crc_in   = crcpr_pkg::crc8_step(header_crc_ff, item.data_byte);
               end
            end
            crcpr_pkg::PHASE_BODY: begin
               if (body_room) begin
                  mem_wr_en     = 1'b1;
                  prov_index_in = prov_next;
                  body_crc_in   = body_crc_next;
                  prov_count_in = prov_count_ff + 1'b1;
                  remaining_in  = remaining_dec;
                  if (body_last) begin
                     if (body_good) begin
                        commit_index_in    = prov_next;
                        committed_count_in = prov_count_ff + 1'b1;
                        if (cookie_ff != 8'd0) begin
                           result.resp_valid  = 1'b1;
                           result.resp_code   = crcpr_pkg::RESP_ACK;
                           result.resp_cookie = cookie_ff;
                        end
                     end else begin
                        result.resp_valid  = 1'b1;
                        result.resp_code   = crcpr_pkg::RESP_BAD_DATA;
                        result.resp_cookie = cookie_ff;
                     end
                  end
               end else begin
                  result.resp_valid  = 1'b1;
                  result.resp_code   = crcpr_pkg::RESP_OVERRUN;
                  result.resp_cookie = cookie_ff;
               end
            end
            default: begin
               if (item.data_byte == sync_byte_ff) begin
                  header_crc_in   = item.data_byte;
                  header_index_in = 3'd0;
               end
            end
         endcase
      end

      result.available_count = committed_count_in;
   end

   assign mem_wr_addr = prov_index_ff;
   assign mem_wr_data = item.data_byte;
   assign mem_rd_addr = read_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= crcpr_pkg::PHASE_WAIT;
         sync_byte_ff       <= crcpr_pkg::SYNC_BYTE_RESET;
         header_index_ff    <= '0;
         cookie_ff          <= '0;
         remaining_ff       <= '0;
         expected_crc_ff    <= '0;
         header_crc_ff      <= '0;
         body_crc_ff        <= '0;
         read_index_ff      <= '0;
         commit_index_ff    <= '0;
         prov_index_ff      <= '0;
         committed_count_ff <= '0;
         prov_count_ff      <= '0;
      end else begin
         phase_ff           <= phase_in;
         if (csr_write) begin
            sync_byte_ff <= csr_write_data;
         end
         header_index_ff    <= header_index_in;
         cookie_ff          <= cookie_in;
         remaining_ff       <= remaining_in;
         expected_crc_ff    <= expected_crc_in;
         header_crc_ff      <= header_crc_in;
         body_crc_ff        <= body_crc_in;
         read_index_ff      <= read_index_in;
         commit_index_ff    <= commit_index_in;
         prov_index_ff      <= prov_index_in;
         committed_count_ff <= committed_count_in;
         prov_count_ff      <= prov_count_in;
      end
   end

endmodule

/* design/crcpr_out_stage.sv */
module crcpr_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_accept,
   input  crcpr_pkg::step_result_type  result,
   input  logic [7:0]                  mem_rd_data,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output crcpr_pkg::rsp_payload_type  rsp_payload
);

   // stage 1 waits for the ring read data, stage 2 is the output register
   logic                       s1_valid_ff;
   crcpr_pkg::step_result_type s1_result_ff;
   logic                       out_valid_ff;
   crcpr_pkg::rsp_payload_type out_payload_ff, out_payload_in;
   logic                       advance;

   assign advance   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;

   always_comb begin
      out_payload_in.resp_valid      = s1_result_ff.resp_valid;
      out_payload_in.resp_code       = s1_result_ff.resp_code;
      out_payload_in.resp_cookie     = s1_result_ff.resp_cookie;
      out_payload_in.read_valid      = s1_result_ff.read_valid;
      out_payload_in.read_data       = s1_result_ff.read_valid ? mem_rd_data : 8'h00;
      out_payload_in.available_count = s1_result_ff.available_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (item_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_accept) begin
         s1_result_ff <= result;
      end
      if (advance) begin
         out_payload_ff <= out_payload_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

/* design/crc_checked_packet_receiver_unit.sv */
// Framed serial packet receiver with CRC checks and a committed byte ring.
//
// req_* : one transaction per item, either a received serial byte or a read
//         of one committed byte (opcode). Taken when req_valid && !req_stall.
// rsp_* : exactly one result transaction per request, in request order,
//         carrying the ack/error response, the read byte and the number of
//         committed bytes left. Taken when rsp_valid && !rsp_stall.
// csr_* : write of the sync byte; always ready. Write only while idle.
//
// Throughput is one request per cycle while req_stall is low. The request
// cycle reads/writes the ring memory and updates the framing state, the
// middle stage picks up the registered ring read data, then the result sits
// in the output register. The ring memory read latency sets the middle stage.
// When rsp_stall is held, one more request is taken into the middle stage
// and then req_stall rises until the output register drains.
// Reset (synchronous) clears framing state, indices and counts and restores
// the sync byte to 0xA5; the ring contents need no clearing, since only
// written entries are ever read.
module crc_checked_packet_receiver_unit #(
   parameter int BUFFER_DEPTH = crcpr_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  crcpr_pkg::req_payload_type  req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output crcpr_pkg::rsp_payload_type  rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_write_data
);

   localparam int IDX_W = $clog2(BUFFER_DEPTH);

   logic                       item_accept;
   crcpr_pkg::step_result_type step_result;
   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   logic [7:0]                 mem_wr_data;
   logic                       mem_rd_en;
   logic [IDX_W-1:0]           mem_rd_addr;
   logic [7:0]                 mem_rd_data;

   assign item_accept = req_valid && !req_stall;
   assign csr_ready   = 1'b1;

   // framing, CRCs, ring pointers and counts
   crcpr_frame_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_frame_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid && csr_ready),
      .csr_write_data (csr_write_data),
      .item_accept    (item_accept),
      .item           (req_payload),
      .result         (step_result),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr)
   );

   // ring buffer; a byte written by one transaction is readable by the next
   crcpr_ring_mem #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // read-latency stage plus output register
   crcpr_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .result      (step_result),
      .mem_rd_data (mem_rd_data),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   // requests back up only behind a full, stalled output
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled while output can drain");

   // an accepted request reaches the output when the output is not stalled
   a_result_arrives: assert property (@(posedge clock) disable iff (reset)
      (item_accept ##1 !rsp_stall) |=> rsp_valid)
      else $error("result lost in pipeline");

   // ring occupancy never reaches the full depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_payload.available_count) <= BUFFER_DEPTH - 1))
      else $error("committed count exceeds ring capacity");
`endif

endmodule

/* tb/packet_receiver_checker.sv */
module packet_receiver_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  crcpr_pkg::req_payload_type req_payload,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  crcpr_pkg::rsp_payload_type rsp_payload,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [7:0]                 csr_write_data,
   output int                         mismatches,
   output int                         outstanding
);

   localparam int RING_DEPTH = crcpr_pkg::BUFFER_DEPTH_DEFAULT;

   // shadow of the receiver state
   logic [7:0]           sync_value;
   crcpr_pkg::phase_type rx_phase;
   logic [2:0]           hdr_count;
   logic [7:0]           pkt_cookie;
   logic [7:0]           body_left;
   logic [15:0]          want_crc;
   logic [7:0]           hdr_crc;
   logic [15:0]          body_crc;
   logic [7:0]           ring [RING_DEPTH];
   logic [7:0]           rd_ptr;
   logic [7:0]           commit_ptr;
   logic [7:0]           prov_ptr;
   logic [7:0]           avail_cnt;
   logic [7:0]           prov_cnt;

   crcpr_pkg::rsp_payload_type awaited_rsp [$];
   crcpr_pkg::rsp_payload_type want_rsp;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc ^ d;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) c = (c << 1) ^ crcpr_pkg::CRC8_POLY;
         else c = c << 1;
      end
      return c;
   endfunction

   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      c = crc ^ {8'h00, d};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) c = (c >> 1) ^ crcpr_pkg::CRC16_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   // advances the shadow state by one request, returns the result it must give
   function automatic crcpr_pkg::rsp_payload_type frame_step(
      input crcpr_pkg::req_payload_type r);
      crcpr_pkg::rsp_payload_type o;
      logic [7:0]                 d;
      o = '0;
      d = r.data_byte;
      if (r.opcode == crcpr_pkg::OP_READ) begin
         if (avail_cnt != 8'd0) begin
            o.read_valid = 1'b1;
            o.read_data  = ring[rd_ptr];
            rd_ptr++;
            avail_cnt--;
            prov_cnt--;
         end
      end else if (rx_phase == crcpr_pkg::PHASE_HEADER) begin
         if (hdr_count >= 3'd4) begin
            if (d == hdr_crc) begin
               if (body_left != 8'd0) begin
                  body_crc = crcpr_pkg::CRC16_INIT;
                  prov_ptr = commit_ptr;
                  prov_cnt = avail_cnt;
                  rx_phase = crcpr_pkg::PHASE_BODY;
               end else begin
                  if (pkt_cookie != 8'd0) begin
                     o.resp_valid  = 1'b1;
                     o.resp_code   = crcpr_pkg::RESP_ACK;
                     o.resp_cookie = pkt_cookie;
                  end
                  rx_phase = crcpr_pkg::PHASE_WAIT;
               end
            end else begin
               o.resp_valid = 1'b1;
               o.resp_code  = crcpr_pkg::RESP_BAD_HEADER;
               rx_phase     = crcpr_pkg::PHASE_WAIT;
            end
         end else begin
            case (hdr_count)
               3'd0: pkt_cookie = d;
               3'd1: body_left = d;
               3'd2: want_crc[7:0] = d;
               default: want_crc[15:8] = d;
            endcase
            hdr_count++;
            hdr_crc = crc8_next(hdr_crc, d);
         end
      end else if (rx_phase == crcpr_pkg::PHASE_BODY) begin
         if (int'(prov_cnt) < RING_DEPTH - 1) begin
            ring[prov_ptr] = d;
            prov_ptr++;
            body_crc = crc16_next(body_crc, d);
            prov_cnt++;
            body_left--;
            if (body_left == 8'd0) begin
               if (want_crc == 16'h0000 || body_crc == want_crc) begin
                  commit_ptr = prov_ptr;
                  avail_cnt  = prov_cnt;
                  if (pkt_cookie != 8'd0) begin
                     o.resp_valid  = 1'b1;
                     o.resp_code   = crcpr_pkg::RESP_ACK;
                     o.resp_cookie = pkt_cookie;
                  end
               end else begin
                  o.resp_valid  = 1'b1;
                  o.resp_code   = crcpr_pkg::RESP_BAD_DATA;
                  o.resp_cookie = pkt_cookie;
               end
               rx_phase = crcpr_pkg::PHASE_WAIT;
            end
         end else begin
            // ring full: byte dropped, packet abandoned
            o.resp_valid  = 1'b1;
            o.resp_code   = crcpr_pkg::RESP_OVERRUN;
            o.resp_cookie = pkt_cookie;
            rx_phase      = crcpr_pkg::PHASE_WAIT;
         end
      end else begin
         rx_phase = crcpr_pkg::PHASE_WAIT;
         if (d == sync_value) begin
            hdr_crc   = d;
            hdr_count = 3'd0;
            rx_phase  = crcpr_pkg::PHASE_HEADER;
         end
      end
      o.available_count = avail_cnt;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sync_value = crcpr_pkg::SYNC_BYTE_RESET;
         rx_phase   = crcpr_pkg::PHASE_WAIT;
         hdr_count  = 3'd0;
         pkt_cookie = 8'd0;
         body_left  = 8'd0;
         want_crc   = 16'd0;
         hdr_crc    = 8'd0;
         body_crc   = 16'd0;
         rd_ptr     = 8'd0;
         commit_ptr = 8'd0;
         prov_ptr   = 8'd0;
         avail_cnt  = 8'd0;
         prov_cnt   = 8'd0;
         awaited_rsp.delete();
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) sync_value = csr_write_data;
         if (req_valid && !req_stall) awaited_rsp.push_back(frame_step(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %0h",
                        $time, rsp_payload);
               mismatches++;
            end else begin
               want_rsp = awaited_rsp.pop_front();
               check_field("resp_valid", want_rsp.resp_valid, rsp_payload.resp_valid);
               check_field("resp_code", want_rsp.resp_code, rsp_payload.resp_code);
               check_field("resp_cookie", want_rsp.resp_cookie, rsp_payload.resp_cookie);
               check_field("read_valid", want_rsp.read_valid, rsp_payload.read_valid);
               check_field("read_data", want_rsp.read_data, rsp_payload.read_data);
               check_field("available_count", want_rsp.available_count,
                           rsp_payload.available_count);
            end
         end
         outstanding <= awaited_rsp.size();
      end
   end

endmodule

/* tb/crc_checked_packet_receiver_unit_test.sv */
module crc_checked_packet_receiver_unit_test;

   typedef logic [7:0] byte_queue_type [$];

   // how a generated frame is damaged, if at all
   typedef enum logic [1:0] {
      FRAME_GOOD,
      FRAME_BAD_CHECK,
      FRAME_BAD_CRC,
      FRAME_NO_CRC
   } frame_kind_type;

   // receiver back-pressure styles
   typedef enum logic [1:0] {
      STALL_NEVER,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   localparam int PHASE_ITEMS    = 25;
   localparam int SQUEEZE_CYCLES = 80;
   // leave plenty of margin over the worst-case run time
   localparam int RUN_LIMIT      = 2_000_000;

   logic                       clock;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   crcpr_pkg::req_payload_type req_payload    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   crcpr_pkg::rsp_payload_type rsp_payload;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [7:0]                 csr_write_data = 8'h00;
   logic                       squeeze        = 1'b0;

   int              mismatches;
   int              outstanding;

   // sender burst state and the sync byte the block currently holds
   int              burst_left = 0;
   int              items_sent = 0;
   logic [7:0]      sync_now   = crcpr_pkg::SYNC_BYTE_RESET;

   crc_checked_packet_receiver_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_write_data (csr_write_data)
   );

   packet_receiver_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_write_data (csr_write_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Header check byte: CRC-8 seeded with the sync byte over cookie, length,
   // CRC low, CRC high (hdr holds them in that order from the top down).
   function automatic logic [7:0] header_check(input logic [7:0] seed, input logic [31:0] hdr);
      logic [7:0] c;
      c = seed;
      for (int b = 3; b >= 0; b--) begin
         c ^= hdr[b*8 +: 8];
         repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? crcpr_pkg::CRC8_POLY : 8'h00);
      end
      return c;
   endfunction

   // Body CRC as the sender would compute it: reflected CCITT over all bytes.
   function automatic logic [15:0] payload_crc(input byte_queue_type body);
      logic [15:0] c;
      c = crcpr_pkg::CRC16_INIT;
      foreach (body[i]) begin
         c ^= {8'h00, body[i]};
         repeat (8) c = (c >> 1) ^ (c[0] ? crcpr_pkg::CRC16_POLY : 16'h0000);
      end
      return c;
   endfunction

   // Builds the wire image of one packet: sync, cookie, length, CRC (low
   // first), header check, body. The kind breaks one check or zeroes the CRC.
   task automatic build_frame(input logic [7:0] cookie, input byte_queue_type body,
                              input frame_kind_type kind, output byte_queue_type frame);
      logic [15:0] crc;
      logic [7:0]  len;
      logic [7:0]  check;
      crc = (kind == FRAME_NO_CRC) ? 16'h0000 : payload_crc(body);
      if (kind == FRAME_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
      len = 8'(body.size());
      check = header_check(sync_now, {cookie, len, crc[7:0], crc[15:8]});
      if (kind == FRAME_BAD_CHECK) check ^= 8'($urandom_range(1, 255));
      frame = {sync_now, cookie, len, crc[7:0], crc[15:8], check};
      foreach (body[i]) frame.push_back(body[i]);
   endtask

   // Offers one transaction. The sender runs in bursts; at the start of each
   // burst it may drop valid for a random gap. Valid is only ever raised or
   // lowered once per clock edge, and never depends on req_stall.
   task automatic push_item(input crcpr_pkg::opcode_type op, input logic [7:0] d);
      int                         gap;
      crcpr_pkg::req_payload_type p;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      p.opcode    = op;
      p.data_byte = d;
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   // Sends the bytes of a frame; consumer reads get sprinkled in between,
   // including in the middle of the header and the body.
   task automatic push_bytes(input byte_queue_type bytes, input int rd_pct);
      foreach (bytes[i]) begin
         while ($urandom_range(0, 99) < rd_pct) begin
            push_item(crcpr_pkg::OP_READ, 8'($urandom_range(0, 255)));
         end
         push_item(crcpr_pkg::OP_RX_BYTE, bytes[i]);
      end
   endtask

   // Stops offering and waits until every result is back, then lets the
   // two-stage pipeline settle. Needed before any CSR write.
   task automatic drain_pipeline;
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sync(input logic [7:0] v);
      csr_valid      <= 1'b1;
      csr_write_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sync_now = v;
   endtask

   // Mostly packets with random content, some with a broken check, the rest read bursts,
   // stray bytes and frames cut off inside the header.
   task automatic random_traffic(input int quota, input int rd_pct);
      int             stop;
      int             pick;
      int             len;
      int             n;
      byte_queue_type body;
      byte_queue_type frame;
      frame_kind_type kind;
      logic [7:0]     cookie;
      stop = items_sent + quota;
      while (items_sent < stop) begin
         pick = $urandom_range(0, 99);
         cookie = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
         if (pick < 70) begin
            // short bodies mostly, now and then a longer one
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            n = $urandom_range(0, 99);
            kind = (n < 60) ? FRAME_GOOD :
                   (n < 75) ? FRAME_BAD_CHECK :
                   (n < 90) ? FRAME_BAD_CRC : FRAME_NO_CRC;
            body.delete();
            repeat (len) body.push_back(8'($urandom_range(0, 255)));
            build_frame(cookie, body, kind, frame);
            push_bytes(frame, rd_pct);
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) begin
               push_item(crcpr_pkg::OP_READ, 8'($urandom_range(0, 255)));
            end
         end else if (pick < 93) begin
            repeat ($urandom_range(1, 3)) begin
               push_item(crcpr_pkg::OP_RX_BYTE, 8'($urandom_range(0, 255)));
            end
         end else begin
            // truncated frame: the next packet's bytes land in this header
            body.delete();
            build_frame(cookie, body, FRAME_GOOD, frame);
            n = $urandom_range(1, 5);
            while (frame.size() > n) void'(frame.pop_back());
            push_bytes(frame, 0);
         end
      end
   endtask

   // Receiver back-pressure: changes style at random intervals. Once,
   // on request from the stimulus, it holds off for a long stretch so the
   // block fills up and has to stall its input.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      bit             squeezed;
      mode      = STALL_NEVER;
      mode_left = 0;
      squeezed  = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeezed) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(10, 60);
            end
            mode_left--;
            case (mode)
               STALL_NEVER: rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 20);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 70);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // Main stimulus
   initial begin
      byte_queue_type body;
      byte_queue_type frame;
      logic [7:0]     sync_plan [4];
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with the sync byte at its reset value.
      // Read of an empty buffer: not valid, nothing changes.
      push_item(crcpr_pkg::OP_READ, 8'hFF);
      // Good two-byte packet, cookie 0xFF: ack and two bytes committed.
      body = {8'h00, 8'hFF};
      build_frame(8'hFF, body, FRAME_GOOD, frame);
      push_bytes(frame, 0);
      // One-byte packet with zero cookie and the CRC check skipped, with a
      // read slipped in once the body has started: commits silently.
      body = {8'h5A};
      build_frame(8'h00, body, FRAME_NO_CRC, frame);
      foreach (frame[i]) begin
         if (i == 6) push_item(crcpr_pkg::OP_READ, 8'h00);
         push_item(crcpr_pkg::OP_RX_BYTE, frame[i]);
      end
      // Corrupt header check byte: error with zero cookie.
      body.delete();
      build_frame(8'hFF, body, FRAME_BAD_CHECK, frame);
      push_bytes(frame, 0);
      push_item(crcpr_pkg::OP_READ, 8'h00);

      // Random part, one phase per sync byte setting, extremes included.
      sync_plan = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), crcpr_pkg::SYNC_BYTE_RESET};
      for (int p = 0; p < 4; p++) begin
         drain_pipeline();
         write_sync(sync_plan[p]);
         if (p == 2) begin
            // Fill the ring: a maximum-length packet, then another one, with
            // no reads, so the ring overruns and the indices wrap. The long
            // receiver hold-off runs during this.
            squeeze <= 1'b1;
            body.delete();
            repeat (255) body.push_back(8'($urandom_range(0, 255)));
            build_frame(8'($urandom_range(1, 255)), body, FRAME_NO_CRC, frame);
            push_bytes(frame, 0);
            body.delete();
            repeat (10) body.push_back(8'($urandom_range(0, 255)));
            build_frame(8'($urandom_range(1, 255)), body, FRAME_GOOD, frame);
            push_bytes(frame, 0);
         end
         // last phase reads heavily to drain what the fill left behind
         random_traffic(PHASE_ITEMS, (p == 3) ? 50 : $urandom_range(0, 30));
      end

      drain_pipeline();
      if (mismatches == 0) begin
         $display("crc_checked_packet_receiver_unit_test passed");
      end else begin
         $display("crc_checked_packet_receiver_unit_test failed");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #(RUN_LIMIT);
      $display("crc_checked_packet_receiver_unit_test failed");
      $finish;
   end

endmodule

/* files.f */
design/crcpr_pkg.sv
design/crcpr_ring_mem.sv
design/crcpr_frame_ctrl.sv
design/crcpr_out_stage.sv
design/crc_checked_packet_receiver_unit.sv
tb/packet_receiver_checker.sv
tb/crc_checked_packet_receiver_unit_test.sv
